// File: rtl/core/running_mean_variance_stats_core_assert.svh
// Assertion macros used by the checker of the statistics core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RUNNING_MEAN_VARIANCE_STATS_CORE_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_STATS_CORE_ASSERT_SVH

// Same-cycle implication
`define RMVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RMVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rmvs_pkg.sv
`timescale 1ns / 1ps
package rmvs_pkg;

    // Sample counter width; the counter saturates at all ones
    localparam int COUNT_BITS = 20;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam int DIV_BITS  = 64;   // dividend / quotient width
    localparam int DEN_BITS  = 32;   // divisor width
    localparam int RAD_BITS  = 64;   // square root radicand width
    localparam int ROOT_BITS = 32;
    localparam int MUL_BITS  = 49;   // multiplier operand width
    localparam int PROD_BITS = 50;   // floor(a * b / 2^48)

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DM_GO,     // delta / count
        ST_DM_WAIT,
        ST_MUL_GO,    // delta * d2
        ST_MUL_WAIT,
        ST_CHECK,
        ST_DV_GO,     // deviation sum / (count - 1)
        ST_DV_WAIT,
        ST_SD_GO,     // std_dev root
        ST_SD_WAIT,
        ST_DS_GO,     // (v << 16) / count
        ST_DS_WAIT,
        ST_DW_GO,     // v / count, large-variance path
        ST_DW_WAIT,
        ST_SE_GO,     // std_error root
        ST_SE_WAIT,
        ST_REL_GO,    // relative error division
        ST_REL_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [DEN_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic                start;
        logic [RAD_BITS-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic                 done;
        logic [ROOT_BITS-1:0] root;
    } sqrt_rsp_t;

    typedef struct packed {
        logic                start;
        logic [MUL_BITS-1:0] a;
        logic [MUL_BITS-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                 done;
        logic [PROD_BITS-1:0] prod;
    } mul_rsp_t;

endpackage

// File: rtl/core/rmvs_if.sv
`timescale 1ns / 1ps
// Sample request channel
interface rmvs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

// Statistics result channel
interface rmvs_out_if;
    import rmvs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] sample_count;
    logic signed [31:0]    running_mean;
    logic [31:0]           std_dev;
    logic [31:0]           std_error;
    logic [31:0]           relative_error;

    modport source (output valid, output sample_count, output running_mean,
                    output std_dev, output std_error, output relative_error,
                    input ready);
    modport sink   (input valid, input sample_count, input running_mean,
                    input std_dev, input std_error, input relative_error,
                    output ready);
endinterface

// File: rtl/core/rmvs_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle
module rmvs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rmvs_pkg::div_req_t req,
    output rmvs_pkg::div_rsp_t rsp
);
    import rmvs_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS);

    logic [DIV_BITS-1:0] num_reg, num_next;
    logic [DEN_BITS-1:0] den_reg;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg, done_reg;
    logic [DEN_BITS:0]   shifted, diff;
    logic                ge;

    // One restoring step
    always_comb
    begin
        shifted  = {rem_reg, num_reg[DIV_BITS-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = (shifted >= {1'b0, den_reg});
        rem_next = ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
        num_next = {num_reg[DIV_BITS-2:0], ge};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;
endmodule

// File: rtl/core/rmvs_sqrt.sv
`timescale 1ns / 1ps
// Integer square root, one root bit (two radicand bits) per cycle
module rmvs_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  rmvs_pkg::sqrt_req_t req,
    output rmvs_pkg::sqrt_rsp_t rsp
);
    import rmvs_pkg::*;

    localparam int CNT_W = $clog2(ROOT_BITS);

    logic [RAD_BITS-1:0]  rad_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [ROOT_BITS:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg, done_reg;
    logic [ROOT_BITS+2:0] trial, test, diff;
    logic                 ge;

    // Bring down two bits and try root*4+1
    always_comb
    begin
        trial    = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
        test     = {1'b0, root_reg, 2'b01};
        diff     = trial - test;
        ge       = (trial >= test);
        rem_next = ge ? diff[ROOT_BITS:0] : trial[ROOT_BITS:0];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_BITS-2:0], ge};
            rem_reg  <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
endmodule

// File: rtl/core/rmvs_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle; returns floor(a * b / 2^48)
module rmvs_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  rmvs_pkg::mul_req_t req,
    output rmvs_pkg::mul_rsp_t rsp
);
    import rmvs_pkg::*;

    localparam int CNT_W = $clog2(MUL_BITS);

    logic [MUL_BITS-1:0]   a_reg, b_reg;
    logic [2*MUL_BITS-1:0] acc_reg;
    logic [MUL_BITS:0]     sum;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg, done_reg;

    // Add the partial product to the upper half, then shift right
    always_comb
    begin
        sum = {1'b0, acc_reg[2*MUL_BITS-1:MUL_BITS]}
            + (b_reg[0] ? {1'b0, a_reg} : '0);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= {1'b0, b_reg[MUL_BITS-1:1]};
            acc_reg <= {sum, acc_reg[MUL_BITS-1:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg[2*MUL_BITS-1 -: PROD_BITS];
endmodule

// File: rtl/core/running_mean_variance_stats_core.sv
`timescale 1ns / 1ps
// Channel     Dir   Contents
// sample_ch   in    sample (Q16.16 signed), restart
// result_ch   out   sample_count, running_mean, std_dev, std_error, relative_error
//
// One request at a time. First sample: one division and one multiply. Later
// samples: one multiply, four passes through the shared bit-serial divider, and
// up to two passes through the bit-serial square root unit.
// Reset clears count, mean and deviation sum; the result register holds while
// result_ch stalls, and a new request is taken once the result is stored.
module running_mean_variance_stats_core (
    input  logic         clk,
    input  logic         rst_n,
    rmvs_in_if.sink      sample_ch,
    rmvs_out_if.source   result_ch
);
    import rmvs_pkg::*;

    state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] count_reg;
    logic signed [47:0]    mean_reg;
    logic [63:0]           dev_reg;
    logic signed [31:0]    x_reg;
    logic signed [48:0]    delta_reg;
    logic [63:0]           work_reg;
    logic [31:0]           stdv_reg, se_reg, rel_reg;

    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic signed [31:0]    out_mean_reg;
    logic [31:0]           out_stdv_reg, out_se_reg, out_rel_reg;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;
    mul_req_t  mul_req;
    mul_rsp_t  mul_rsp;

    logic                  accept;
    logic [COUNT_BITS-1:0] cnt_base;
    logic signed [48:0]    xw, delta, d2;
    logic [48:0]           delta_mag, d2_mag;
    logic [47:0]           q_signed;
    logic [64:0]           dev_sum;
    logic [31:0]           mean_out, den;
    logic                  out_load;

    rmvs_div  u_div  (.clk(clk), .rst_n(rst_n), .req(div_req),  .rsp(div_rsp));
    rmvs_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sqrt_req), .rsp(sqrt_rsp));
    rmvs_mul  u_mul  (.clk(clk), .rst_n(rst_n), .req(mul_req),  .rsp(mul_rsp));

    // Datapath helpers
    always_comb
    begin
        accept    = sample_ch.valid && (state_reg == ST_IDLE);
        cnt_base  = sample_ch.restart ? '0 : count_reg;
        xw        = {x_reg[31], x_reg, 16'h0000};
        delta     = xw - {mean_reg[47], mean_reg};
        d2        = delta;
        delta_mag = delta_reg[48] ? 49'(-delta_reg) : 49'(delta_reg);
        d2_mag    = d2[48] ? 49'(-d2) : 49'(d2);
        q_signed  = delta_reg[48] ? 48'(-div_rsp.quot[47:0]) : div_rsp.quot[47:0];
        dev_sum   = {1'b0, dev_reg} + {15'h0, mul_rsp.prod};
        mean_out  = mean_reg[47:16];
        den       = mean_out[31] ? 32'(-mean_out) : mean_out;
        if (den == 32'h0)
        begin
            den = 32'h1;
        end
        out_load  = (state_reg == ST_OUT) && (!out_valid_reg || result_ch.ready);
    end

    // Unit requests
    always_comb
    begin
        div_req  = '0;
        sqrt_req = '0;
        mul_req  = '0;
        case (state_reg)
            ST_DM_GO:
            begin
                // delta_reg is loaded at this edge; take |delta| straight from the mean
                div_req.start    = 1'b1;
                div_req.dividend = 64'(d2_mag);
                div_req.divisor  = 32'(count_reg);
            end
            ST_MUL_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = delta_mag;
                mul_req.b     = d2_mag;
            end
            ST_DV_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = dev_reg;
                div_req.divisor  = 32'(count_reg - 1'b1);
            end
            ST_SD_GO:
            begin
                sqrt_req.start    = 1'b1;
                sqrt_req.radicand = {work_reg[47:0], 16'h0000};
            end
            ST_DS_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {work_reg[47:0], 16'h0000};
                div_req.divisor  = 32'(count_reg);
            end
            ST_DW_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = work_reg;
                div_req.divisor  = 32'(count_reg);
            end
            ST_SE_GO:
            begin
                sqrt_req.start    = 1'b1;
                sqrt_req.radicand = work_reg;
            end
            ST_REL_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {8'h00, se_reg, 24'h000000};
                div_req.divisor  = den;
            end
            default:
            begin
                div_req  = '0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_DM_GO;
            ST_DM_GO:    state_next = ST_DM_WAIT;
            ST_DM_WAIT:  if (div_rsp.done) state_next = ST_MUL_GO;
            ST_MUL_GO:   state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: if (mul_rsp.done) state_next = ST_CHECK;
            ST_CHECK:    state_next = (count_reg < COUNT_BITS'(2)) ? ST_OUT : ST_DV_GO;
            ST_DV_GO:    state_next = ST_DV_WAIT;
            ST_DV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (div_rsp.quot[63:48] == 16'h0) ? ST_SD_GO : ST_DW_GO;
                end
            end
            ST_SD_GO:    state_next = ST_SD_WAIT;
            ST_SD_WAIT:  if (sqrt_rsp.done) state_next = ST_DS_GO;
            ST_DS_GO:    state_next = ST_DS_WAIT;
            ST_DS_WAIT:  if (div_rsp.done) state_next = ST_SE_GO;
            ST_DW_GO:    state_next = ST_DW_WAIT;
            ST_DW_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (div_rsp.quot[63:48] == 16'h0) ? ST_SE_GO : ST_REL_GO;
                end
            end
            ST_SE_GO:    state_next = ST_SE_WAIT;
            ST_SE_WAIT:  if (sqrt_rsp.done) state_next = ST_REL_GO;
            ST_REL_GO:   state_next = ST_REL_WAIT;
            ST_REL_WAIT: if (div_rsp.done) state_next = ST_OUT;
            ST_OUT:      if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mean_reg  <= '0;
            dev_reg   <= '0;
        end
        else if (accept)
        begin
            count_reg <= (cnt_base != COUNT_MAX) ? cnt_base + 1'b1 : cnt_base;
            if (sample_ch.restart)
            begin
                mean_reg <= '0;
                dev_reg  <= '0;
            end
        end
        else if (state_reg == ST_DM_WAIT && div_rsp.done)
        begin
            mean_reg <= mean_reg + q_signed;
        end
        else if (state_reg == ST_MUL_WAIT && mul_rsp.done)
        begin
            dev_reg <= dev_sum[64] ? {64{1'b1}} : dev_sum[63:0];
        end
    end

    // Per-request scratch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sample_ch.sample;
            stdv_reg <= '0;
            se_reg   <= '0;
            rel_reg  <= '0;
        end
        case (state_reg)
            ST_DM_GO:   delta_reg <= delta;
            ST_DV_WAIT: if (div_rsp.done) work_reg <= div_rsp.quot;
            ST_SD_WAIT: if (sqrt_rsp.done) stdv_reg <= sqrt_rsp.root;
            ST_DS_WAIT: if (div_rsp.done) work_reg <= div_rsp.quot;
            ST_DW_GO:   stdv_reg <= '1;
            ST_DW_WAIT:
            begin
                if (div_rsp.done)
                begin
                    work_reg <= {div_rsp.quot[47:0], 16'h0000};
                    if (div_rsp.quot[63:48] != 16'h0)
                    begin
                        se_reg <= '1;
                    end
                end
            end
            ST_SE_WAIT: if (sqrt_rsp.done) se_reg <= sqrt_rsp.root;
            ST_REL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    rel_reg <= (div_rsp.quot[63:32] != 32'h0) ? '1 : div_rsp.quot[31:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_count_reg <= count_reg;
            out_mean_reg  <= mean_out;
            out_stdv_reg  <= stdv_reg;
            out_se_reg    <= se_reg;
            out_rel_reg   <= rel_reg;
        end
    end

    assign sample_ch.ready          = (state_reg == ST_IDLE);
    assign result_ch.valid          = out_valid_reg;
    assign result_ch.sample_count   = out_count_reg;
    assign result_ch.running_mean   = out_mean_reg;
    assign result_ch.std_dev        = out_stdv_reg;
    assign result_ch.std_error      = out_se_reg;
    assign result_ch.relative_error = out_rel_reg;
endmodule

// File: rtl/core/rmvs_checker.sv
`timescale 1ns / 1ps
`include "running_mean_variance_stats_core_assert.svh"
// Port-level checks for the statistics core
module rmvs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_count,
    input logic [31:0] out_stdv,
    input logic [31:0] out_se,
    input logic [31:0] out_rel
);
    // Stalled result stays offered
    `RMVS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")
    // One request in flight: busy right after a request is taken
    `RMVS_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready, "second request taken early")
    // Every result reports at least one sample
    `RMVS_ASSERT_NOW(a_count_nz, out_valid, out_count != 32'h0, "zero sample count")
    // Spread is zero until two samples are in
    `RMVS_ASSERT_NOW(a_single, out_valid && out_count < 32'h2,
        out_stdv == 32'h0 && out_se == 32'h0 && out_rel == 32'h0, "spread with one sample")
endmodule

bind running_mean_variance_stats_core rmvs_checker u_rmvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_count (32'(result_ch.sample_count)),
    .out_stdv  (result_ch.std_dev),
    .out_se    (result_ch.std_error),
    .out_rel   (result_ch.relative_error)
);
